// ===== rtl/arsc_pkg.sv =====
`timescale 1ns / 1ps
package arsc_pkg;
    localparam int MAX_SIGNERS = 16;
    localparam int WORD_BITS   = 64;

    typedef enum logic [1:0] {
        OP_LOAD_KEY  = 2'd0,
        OP_LOAD_HASH = 2'd1,
        OP_COMPUTE   = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_MANY_HASHES = 3'd1;
    localparam logic [2:0] ST_MANY_KEYS   = 3'd2;
    localparam logic [2:0] ST_NO_KEYS     = 3'd3;
    localparam logic [2:0] ST_OVERFLOW    = 3'd4;

    localparam logic [1:0] POL_MATCH    = 2'd0;
    localparam logic [1:0] POL_EXTRA    = 2'd1;
    localparam logic [1:0] POL_NONE     = 2'd2;
    localparam logic [1:0] POL_RESERVED = 2'd3;
endpackage

// ===== rtl/aggregate_rsa_sign_chain_unit.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Contents
// s_axis   in         tdata: operation[1:0], modulus, exponent, hash_value
// m_axis   out        tdata: signature, status
// cfg      in         count_policy[1:0]
// Load items are accepted in the idle state, which they do not leave. A compute item first
// sorts the K keys in place (insertion sort, one memory access per cycle), then per key
// reduces the hash, multiplies it by the running signature for every key after the first,
// and runs square-and-multiply over all WORD_BITS exponent bits. Each modular multiply holds
// the single bit-serial multiplier until its done strobe; moduli zero and one skip a key
// and set the running signature to zero.
// Load items are accepted while a result waits; a compute item waits until it is taken.
// Reset clears counts, flags and policy; the stores are undefined until written.
module aggregate_rsa_sign_chain_unit #(
    parameter int MAX_SIGNERS = arsc_pkg::MAX_SIGNERS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [199:0] s_tdata,   // operation[1:0], modulus, exponent, hash_value, pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // signature[63:0], status[66:64], pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_data
);
    localparam int AW = (MAX_SIGNERS > 1) ? $clog2(MAX_SIGNERS) : 1;
    localparam int CW = $clog2(MAX_SIGNERS + 1);
    localparam int W  = arsc_pkg::WORD_BITS;
    localparam int EW = $clog2(W + 1);

    typedef enum logic [4:0] {
        IDLE, SO_RD, SO_WT, SI_RD, SI_WT, SI_CMP, SI_PUT,
        CH_RD, CH_WT, CH_HW, CH_RED, CH_MUL, CH_MWT, CH_EXP, CH_BM, CH_BW,
        CH_SQ, CH_SW, CH_NEXT, EMIT
    } state_t;

    state_t state_reg;
    logic [1:0] policy_reg;
    logic [CW-1:0] kc_reg, hc_reg;
    logic ovf_reg;

    // Key store: {modulus, exponent}; hash store separate.
    logic [2*W-1:0] key_mem [MAX_SIGNERS];
    logic [W-1:0]   hash_mem [MAX_SIGNERS];
    logic [2*W-1:0] key_rd_reg;
    logic [W-1:0]   hash_rd_reg;
    logic           kwe;
    logic [AW-1:0]  kwa, kra, hra;
    logic [2*W-1:0] kwd;

    logic [CW-1:0] i_reg, j_reg, hi_reg;
    logic [2*W-1:0] cur_reg;
    logic [W-1:0] n_reg, d_reg, s_reg, r_reg, b_reg;
    logic [EW-1:0] ebit_reg;
    logic [W-1:0] sig_reg;
    logic [2:0] st_reg;
    logic out_v_reg;

    logic [1:0] op;
    logic [W-1:0] in_mod, in_exp, in_hash;
    assign op      = s_tdata[1:0];
    assign in_mod  = s_tdata[2 +: W];
    assign in_exp  = s_tdata[66 +: W];
    assign in_hash = s_tdata[130 +: W];

    logic s_acc;
    assign s_tready  = (state_reg == IDLE) && !(out_v_reg && op == arsc_pkg::OP_COMPUTE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // One multiplier serves the chain product, the squarings and the multiplies.
    logic mm_start, mm_done;
    logic [W-1:0] mm_a, mm_b, mm_n, mm_r;
    arsc_modmul #(.WORD_BITS(W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mm_start),
        .a_in(mm_a), .b_in(mm_b), .n_in(mm_n), .done(mm_done), .result(mm_r)
    );

    // Plain reduction of a W-bit value mod n: restoring, one bit per cycle.
    logic [W:0] rem_reg;
    logic [W-1:0] red_src_reg;
    logic [EW-1:0] red_cnt_reg;
    logic [W:0] rem_sh;
    assign rem_sh = {rem_reg[W-1:0], red_src_reg[W-1]};

    logic [2:0] status_c;
    always_comb begin
        if (ovf_reg) status_c = arsc_pkg::ST_OVERFLOW;
        else if (hc_reg > kc_reg && policy_reg <= arsc_pkg::POL_EXTRA)
            status_c = arsc_pkg::ST_MANY_HASHES;
        else if (kc_reg > hc_reg && policy_reg == arsc_pkg::POL_MATCH)
            status_c = arsc_pkg::ST_MANY_KEYS;
        else if (kc_reg == 0) status_c = arsc_pkg::ST_NO_KEYS;
        else if (hc_reg == 0) status_c = arsc_pkg::ST_MANY_KEYS;
        else status_c = arsc_pkg::ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (kwe) key_mem[kwa] <= kwd;
        key_rd_reg <= key_mem[kra];
        if (s_acc && op == arsc_pkg::OP_LOAD_HASH && hc_reg < CW'(MAX_SIGNERS))
            hash_mem[hc_reg[AW-1:0]] <= in_hash;
        hash_rd_reg <= hash_mem[hra];
    end

    always_comb begin
        kwe = 1'b0; kwa = kc_reg[AW-1:0]; kwd = {in_mod, in_exp};
        kra = j_reg[AW-1:0]; hra = hi_reg[AW-1:0];
        mm_start = 1'b0; mm_a = r_reg; mm_b = b_reg; mm_n = n_reg;
        case (state_reg)
            IDLE: begin
                kwe = s_acc && op == arsc_pkg::OP_LOAD_KEY && kc_reg < CW'(MAX_SIGNERS);
            end
            SO_RD: kra = i_reg[AW-1:0];
            SO_WT: kra = i_reg[AW-1:0];
            SI_RD: kra = AW'(j_reg - 1'b1);
            SI_CMP: if (j_reg != 0 && key_rd_reg[2*W-1:W] > cur_reg[2*W-1:W]) begin
                kwe = 1'b1; kwa = j_reg[AW-1:0]; kwd = key_rd_reg;
            end
            SI_PUT: begin kwe = 1'b1; kwa = j_reg[AW-1:0]; kwd = cur_reg; end
            CH_RD: kra = i_reg[AW-1:0];
            CH_MUL: begin mm_start = 1'b1; mm_a = s_reg; mm_b = rem_reg[W-1:0]; end
            CH_BM: begin mm_start = 1'b1; mm_a = r_reg; mm_b = b_reg; end
            CH_SQ: begin mm_start = 1'b1; mm_a = b_reg; mm_b = b_reg; end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE; policy_reg <= '0; kc_reg <= '0; hc_reg <= '0;
            ovf_reg <= 1'b0; out_v_reg <= 1'b0;
        end else begin
            if (cfg_valid) policy_reg <= cfg_data;
            if (out_v_reg && m_tready) out_v_reg <= 1'b0;
            case (state_reg)
                IDLE: if (s_acc) begin
                    case (op)
                        arsc_pkg::OP_LOAD_KEY:
                            if (kc_reg < CW'(MAX_SIGNERS)) kc_reg <= kc_reg + 1'b1;
                            else ovf_reg <= 1'b1;
                        arsc_pkg::OP_LOAD_HASH:
                            if (hc_reg < CW'(MAX_SIGNERS)) hc_reg <= hc_reg + 1'b1;
                            else ovf_reg <= 1'b1;
                        arsc_pkg::OP_COMPUTE: begin
                            st_reg <= status_c;
                            sig_reg <= '0;
                            i_reg <= '0;
                            state_reg <= (status_c == arsc_pkg::ST_OK) ? SO_RD : EMIT;
                        end
                        default: ;
                    endcase
                end
                SO_RD: state_reg <= (i_reg == kc_reg) ? CH_RD : SO_WT;
                SO_WT: begin j_reg <= i_reg; state_reg <= SI_WT; end
                SI_WT: begin cur_reg <= key_rd_reg; state_reg <= SI_RD; end
                SI_RD: state_reg <= (j_reg == 0) ? SI_PUT : SI_CMP;
                SI_CMP: begin
                    if (j_reg != 0 && key_rd_reg[2*W-1:W] > cur_reg[2*W-1:W]) begin
                        j_reg <= j_reg - 1'b1; state_reg <= SI_RD;
                    end else state_reg <= SI_PUT;
                end
                SI_PUT: begin
                    if (i_reg + 1'b1 == kc_reg) begin
                        i_reg <= '0; hi_reg <= '0; state_reg <= CH_RD;
                    end else begin
                        i_reg <= i_reg + 1'b1; state_reg <= SO_RD;
                    end
                end
                CH_RD: state_reg <= CH_WT;
                CH_WT: begin
                    n_reg <= key_rd_reg[2*W-1:W]; d_reg <= key_rd_reg[W-1:0];
                    state_reg <= CH_HW;
                end
                CH_HW: begin
                    if (n_reg <= 1) begin s_reg <= '0; state_reg <= CH_NEXT; end
                    else begin
                        rem_reg <= '0; red_src_reg <= hash_rd_reg; red_cnt_reg <= '0;
                        state_reg <= CH_RED;
                    end
                end
                CH_RED: begin
                    if (rem_sh >= {1'b0, n_reg}) rem_reg <= rem_sh - {1'b0, n_reg};
                    else rem_reg <= rem_sh;
                    red_src_reg <= red_src_reg << 1;
                    red_cnt_reg <= red_cnt_reg + 1'b1;
                    if (red_cnt_reg == EW'(W - 1)) state_reg <= CH_MUL;
                end
                CH_MUL: begin
                    if (i_reg == 0) begin
                        b_reg <= rem_reg[W-1:0]; state_reg <= CH_EXP;
                    end else begin
                        // s_reg is below the previous modulus, which the sort keeps
                        // at or below n, so it needs no reduction.
                        state_reg <= CH_MWT;
                    end
                end
                CH_MWT: if (mm_done) begin b_reg <= mm_r; state_reg <= CH_EXP; end
                CH_EXP: begin
                    r_reg <= W'(1); ebit_reg <= '0; state_reg <= CH_BM;
                end
                CH_BM: state_reg <= CH_BW;
                CH_BW: if (mm_done) begin
                    if (d_reg[0]) r_reg <= mm_r;
                    state_reg <= CH_SQ;
                end
                CH_SQ: state_reg <= CH_SW;
                CH_SW: if (mm_done) begin
                    b_reg <= mm_r; d_reg <= d_reg >> 1; ebit_reg <= ebit_reg + 1'b1;
                    if (ebit_reg == EW'(W - 1)) begin
                        s_reg <= r_reg; state_reg <= CH_NEXT;
                    end else state_reg <= CH_BM;
                end
                CH_NEXT: begin
                    i_reg <= i_reg + 1'b1;
                    hi_reg <= (hi_reg + 1'b1 == hc_reg) ? '0 : hi_reg + 1'b1;
                    if (i_reg + 1'b1 == kc_reg) begin
                        sig_reg <= s_reg; state_reg <= EMIT;
                    end else state_reg <= CH_RD;
                end
                EMIT: if (!out_v_reg) begin
                    out_v_reg <= 1'b1; kc_reg <= '0; hc_reg <= '0; ovf_reg <= 1'b0;
                    state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {5'd0, st_reg, sig_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        kc_reg <= CW'(MAX_SIGNERS))
        else $error("key count beyond store depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st_reg != arsc_pkg::ST_OK |-> sig_reg == '0)
        else $error("nonzero signature with error status");
endmodule

// ===== rtl/arsc_modmul.sv =====
`timescale 1ns / 1ps
// Bit-serial modular multiply: acc = a*b mod n, one bit of b per cycle.
// Inputs must already be reduced below n, n > 0.
module arsc_modmul #(
    parameter int WORD_BITS = arsc_pkg::WORD_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] a_in,
    input  logic [WORD_BITS-1:0] b_in,
    input  logic [WORD_BITS-1:0] n_in,
    output logic                 done,
    output logic [WORD_BITS-1:0] result
);
    localparam int CW = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] a_reg, b_reg, n_reg, acc_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg, done_reg;
    logic [WORD_BITS:0]   sum_acc, sum_a, dbl;
    logic [WORD_BITS-1:0] acc_next, a_next;

    // Sums are one bit wider so the compare against n is exact.
    always_comb begin
        sum_acc  = {1'b0, acc_reg} + {1'b0, a_reg};
        acc_next = (sum_acc >= {1'b0, n_reg}) ? WORD_BITS'(sum_acc - {1'b0, n_reg})
                                              : sum_acc[WORD_BITS-1:0];
        if (!b_reg[0]) acc_next = acc_reg;
        dbl    = {a_reg, 1'b0};
        sum_a  = dbl - {1'b0, n_reg};
        a_next = (dbl >= {1'b0, n_reg}) ? sum_a[WORD_BITS-1:0] : dbl[WORD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            a_reg    <= a_in;
            b_reg    <= b_in;
            n_reg    <= n_in;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            acc_reg  <= acc_next;
            a_reg    <= a_next;
            b_reg    <= b_reg >> 1;
            cnt_reg  <= cnt_reg + 1'b1;
            done_reg <= (cnt_reg == CW'(WORD_BITS - 1));
            if (cnt_reg == CW'(WORD_BITS - 1)) busy_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;
endmodule

// ===== tb/aggregate_sign_checker.sv =====
`timescale 1ns / 1ps
module aggregate_sign_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [199:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_data,
    output int           mismatches,
    output int           pending
);
    typedef struct packed {
        logic [63:0] signature;
        logic [2:0]  status;
    } sig_result_t;

    logic [63:0] moduli [arsc_pkg::MAX_SIGNERS];
    logic [63:0] exps [arsc_pkg::MAX_SIGNERS];
    logic [63:0] hashes [arsc_pkg::MAX_SIGNERS];
    int          n_keys;
    int          n_hashes;
    logic        store_full_hit;
    logic [1:0]  policy;
    sig_result_t expected_sigs[$];

    function automatic logic [63:0] mul_reduce(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] n);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod % {64'd0, n});
    endfunction

    function automatic logic [63:0] exp_reduce(logic [63:0] base, logic [63:0] e,
                                               logic [63:0] n);
        logic [63:0] r;
        if (n <= 64'd1) return 64'd0;
        r = 64'd1;
        base = base % n;
        for (int i = 0; i < 64; i++) begin
            if (e[i]) r = mul_reduce(r, base, n);
            base = mul_reduce(base, base, n);
        end
        return r;
    endfunction

    function automatic logic [63:0] chained_signature();
        logic [63:0] sn [arsc_pkg::MAX_SIGNERS];
        logic [63:0] sd [arsc_pkg::MAX_SIGNERS];
        logic [63:0] s;
        logic [63:0] m;
        int j;
        s = 64'd0;
        // Insertion sort keeps keys with equal moduli in load order.
        for (int i = 0; i < n_keys; i++) begin
            j = i;
            while (j > 0 && sn[j-1] > moduli[i]) begin
                sn[j] = sn[j-1];
                sd[j] = sd[j-1];
                j--;
            end
            sn[j] = moduli[i];
            sd[j] = exps[i];
        end
        for (int i = 0; i < n_keys; i++) begin
            if (sn[i] == 64'd0) begin
                s = 64'd0;
            end else begin
                m = (i == 0) ? hashes[0] % sn[i]
                             : mul_reduce(s, hashes[i % n_hashes], sn[i]);
                s = exp_reduce(m, sd[i], sn[i]);
            end
        end
        return s;
    endfunction

    function automatic sig_result_t predict_compute();
        sig_result_t r;
        r.signature = 64'd0;
        if (store_full_hit) r.status = arsc_pkg::ST_OVERFLOW;
        else if (n_hashes > n_keys && policy <= arsc_pkg::POL_EXTRA)
            r.status = arsc_pkg::ST_MANY_HASHES;
        else if (n_keys > n_hashes && policy == arsc_pkg::POL_MATCH)
            r.status = arsc_pkg::ST_MANY_KEYS;
        else if (n_keys == 0) r.status = arsc_pkg::ST_NO_KEYS;
        else if (n_hashes == 0) r.status = arsc_pkg::ST_MANY_KEYS;
        else r.status = arsc_pkg::ST_OK;
        if (r.status == arsc_pkg::ST_OK) r.signature = chained_signature();
        return r;
    endfunction

    assign pending = expected_sigs.size();

    always @(posedge aclk) begin
        sig_result_t want;
        sig_result_t got;
        if (!aresetn) begin
            n_keys <= 0;
            n_hashes <= 0;
            store_full_hit <= 1'b0;
            policy <= arsc_pkg::POL_MATCH;
            mismatches <= 0;
            expected_sigs.delete();
        end else begin
            if (cfg_valid && cfg_ready) policy <= cfg_data;
            if (s_tvalid && s_tready) begin
                case (arsc_pkg::op_t'(s_tdata[1:0]))
                    arsc_pkg::OP_LOAD_KEY: begin
                        if (n_keys < arsc_pkg::MAX_SIGNERS) begin
                            moduli[n_keys] = s_tdata[65:2];
                            exps[n_keys] = s_tdata[129:66];
                            n_keys <= n_keys + 1;
                        end else begin
                            store_full_hit <= 1'b1;
                        end
                    end
                    arsc_pkg::OP_LOAD_HASH: begin
                        if (n_hashes < arsc_pkg::MAX_SIGNERS) begin
                            hashes[n_hashes] = s_tdata[193:130];
                            n_hashes <= n_hashes + 1;
                        end else begin
                            store_full_hit <= 1'b1;
                        end
                    end
                    arsc_pkg::OP_COMPUTE: begin
                        expected_sigs = {expected_sigs, predict_compute()};
                        n_keys <= 0;
                        n_hashes <= 0;
                        store_full_hit <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.signature = m_tdata[63:0];
                got.status = m_tdata[66:64];
                if (expected_sigs.size() == 0) begin
                    if (mismatches < 10)
                        $display("Unexpected result: signature %h status %0d",
                                 got.signature, got.status);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_sigs.pop_front();
                    if (want != got) begin
                        if (mismatches < 10)
                            $display("Mismatch: expected sig %h st %0d, got sig %h st %0d",
                                     want.signature, want.status, got.signature,
                                     got.status);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [199:0] s_tdata = '0;   // operation, modulus, exponent, hash_value, pad
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;        // signature, status, pad
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_data = '0;
    int           mismatches;
    int           pending;
    int           items_sent;
    int           stall_left;

    always #5 aclk = ~aclk;

    aggregate_rsa_sign_chain_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    aggregate_sign_checker checker_inst (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .mismatches(mismatches), .pending(pending)
    );

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand_word(int bits);
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
        return v;
    endfunction

    // Result side: mostly ready, with short and occasional long stalls.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= gap_length();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(arsc_pkg::op_t op, logic [63:0] modulus,
                             logic [63:0] exponent, logic [63:0] hash_value);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, hash_value, exponent, modulus, op};
        do @(posedge aclk); while (!s_tready);
        if (op != arsc_pkg::OP_NONE) items_sent++;
        gap = gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        // The checker records an item at its accepting edge, so wait for the next edge before looking.
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        // Loads leave no result behind, so give the block a few more cycles.
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_policy(logic [1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_modulus();
        int r;
        r = $urandom_range(0, 39);
        if (r == 0) return 64'd0;
        if (r == 1) return 64'd1;
        if (r == 2) return '1;
        return rand_word($urandom_range(2, 64));
    endfunction

    function automatic logic [63:0] rand_exponent();
        int r;
        r = $urandom_range(0, 39);
        if (r == 0) return 64'd0;
        // Mostly short exponents, with a full-width one now and then.
        if (r < 3) return rand_word(64);
        return rand_word($urandom_range(1, 8));
    endfunction

    task automatic random_set();
        int nk;
        int nh;
        int r;
        r = $urandom_range(0, 19);
        nk = (r == 0) ? 0 : (r == 1) ? $urandom_range(16, 18) : $urandom_range(1, 3);
        r = $urandom_range(0, 19);
        if (r < 10) nh = nk;
        else if (r == 10) nh = $urandom_range(16, 18);
        else nh = $urandom_range(0, 4);
        while (nk + nh > 0) begin
            if ($urandom_range(0, 29) == 0)
                send_item(arsc_pkg::OP_NONE, rand_word(64), rand_word(64), rand_word(64));
            if (nh == 0 || (nk > 0 && $urandom_range(0, 1) == 0)) begin
                send_item(arsc_pkg::OP_LOAD_KEY, rand_modulus(), rand_exponent(),
                          rand_word(64));
                nk--;
            end else begin
                send_item(arsc_pkg::OP_LOAD_HASH, rand_word(64), rand_word(64),
                          rand_word($urandom_range(1, 64)));
                nh--;
            end
        end
        if ($urandom_range(0, 9) != 0)
            send_item(arsc_pkg::OP_COMPUTE, rand_word(64), rand_word(64), rand_word(64));
    endtask

    initial begin
        #1_000_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [1:0] policies [4];
        policies = '{arsc_pkg::POL_MATCH, arsc_pkg::POL_EXTRA, arsc_pkg::POL_NONE,
                     arsc_pkg::POL_RESERVED};
        items_sent = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_policy(arsc_pkg::POL_MATCH);
        // Largest values throughout.
        send_item(arsc_pkg::OP_LOAD_KEY, '1, '1, '1);
        send_item(arsc_pkg::OP_LOAD_HASH, '1, '1, '1);
        send_item(arsc_pkg::OP_COMPUTE, '1, '1, '1);
        // Modulus zero and one, exponent zero, equal moduli keep their order.
        send_item(arsc_pkg::OP_LOAD_KEY, 64'd0, 64'd5, 64'd0);
        send_item(arsc_pkg::OP_LOAD_KEY, 64'd1, 64'd3, 64'd0);
        send_item(arsc_pkg::OP_LOAD_KEY, 64'd1000003, 64'd0, 64'd0);
        send_item(arsc_pkg::OP_LOAD_KEY, 64'd1000003, 64'd7, 64'd0);
        send_item(arsc_pkg::OP_LOAD_HASH, 64'd0, 64'd0, 64'd123456789);
        send_item(arsc_pkg::OP_LOAD_HASH, 64'd0, 64'd0, 64'd0);
        send_item(arsc_pkg::OP_LOAD_HASH, 64'd0, 64'd0, '1);
        send_item(arsc_pkg::OP_LOAD_HASH, 64'd0, 64'd0, 64'd42);
        send_item(arsc_pkg::OP_NONE, '1, '1, '1);
        send_item(arsc_pkg::OP_COMPUTE, 64'd0, 64'd0, 64'd0);
        // No keys, then hashes only, then keys only.
        send_item(arsc_pkg::OP_COMPUTE, 64'd0, 64'd0, 64'd0);
        send_item(arsc_pkg::OP_LOAD_HASH, 64'd0, 64'd0, 64'd9);
        send_item(arsc_pkg::OP_COMPUTE, 64'd0, 64'd0, 64'd0);
        send_item(arsc_pkg::OP_LOAD_KEY, 64'd97, 64'd13, 64'd0);
        send_item(arsc_pkg::OP_COMPUTE, 64'd0, 64'd0, 64'd0);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            write_policy(policies[p]);
            // Keys without hashes under each policy in turn.
            send_item(arsc_pkg::OP_LOAD_KEY, 64'd1009, 64'd3, 64'd0);
            send_item(arsc_pkg::OP_COMPUTE, 64'd0, 64'd0, 64'd0);
            while (items_sent < 60 + (p + 1) * 350) begin
                random_set();
                if (p == 1 && items_sent > 500 && items_sent < 520) begin
                    wait_idle();
                end
            end
            send_item(arsc_pkg::OP_COMPUTE, 64'd0, 64'd0, 64'd0);
            wait_idle();
        end
        write_policy(arsc_pkg::POL_NONE);
        send_item(arsc_pkg::OP_LOAD_KEY, rand_modulus(), rand_exponent(), 64'd0);
        send_item(arsc_pkg::OP_LOAD_HASH, 64'd0, 64'd0, rand_word(64));
        send_item(arsc_pkg::OP_LOAD_HASH, 64'd0, 64'd0, rand_word(64));
        send_item(arsc_pkg::OP_COMPUTE, 64'd0, 64'd0, 64'd0);

        wait_idle();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
